// ===== rtl/sfrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SFR bank package
// Shared word types, register indexes and decode constants for the special
// function register bank and its relocatable serial window.
// ----------------------------------------------------------------------------
package sfrb_pkg;

    typedef struct packed {
        logic        cmd;
        logic [15:0] port_address;
        logic [7:0]  write_data;
    } in_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       claimed;
        logic       clock_slow;
    } out_word_t;

    localparam int unsigned NUM_REGS = 16;
    localparam int unsigned IDX_W    = 4;

    localparam logic        CMD_READ  = 1'b0;
    localparam logic        CMD_WRITE = 1'b1;

    localparam logic [11:0] BANK_PAGE = 12'hfff;

    localparam logic [IDX_W-1:0] IDX_RFC   = 4'h2;
    localparam logic [IDX_W-1:0] IDX_WCY1  = 4'h5;
    localparam logic [IDX_W-1:0] IDX_WCY2  = 4'h6;
    localparam logic [IDX_W-1:0] IDX_SULA  = 4'h8;
    localparam logic [IDX_W-1:0] IDX_OPHA  = 4'hc;
    localparam logic [IDX_W-1:0] IDX_OPSEL = 4'hd;

    localparam int unsigned OPSEL_SER_BIT = 3;

    localparam logic [1:0] SER_DATA    = 2'd0;
    localparam logic [1:0] SER_STATUS  = 2'd1;
    localparam logic [1:0] SER_MODE    = 2'd2;
    localparam logic [1:0] SER_COMMAND = 2'd3;

    localparam logic [7:0] STATUS_RESET   = 8'h05;
    localparam logic [7:0] STATUS_TX_SET  = 8'h05;
    localparam logic [7:0] STATUS_RX_MASK = 8'hfd;
    localparam int unsigned CMD_RESET_BIT = 6;

    localparam logic [7:0] SLOW_RFC  = 8'h84;
    localparam logic [7:0] SLOW_WCY1 = 8'hff;
    localparam logic [7:0] FAST_RFC  = 8'h8d;
    localparam logic [7:0] FAST_WCY1 = 8'hcc;
    localparam logic [7:0] CLK_WCY2  = 8'h0f;

    localparam logic [7:0] UNCLAIMED_DATA = 8'hff;

endpackage

// ===== rtl/sfrb_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SFR bank access channel
// Valid/ready channel that carries one bus access word.
// ----------------------------------------------------------------------------
interface sfrb_in_if;
    logic               valid;
    logic               ready;
    sfrb_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sfrb_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SFR bank result channel
// Valid/ready channel that carries one access result word.
// ----------------------------------------------------------------------------
interface sfrb_out_if;
    logic                valid;
    logic                ready;
    sfrb_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sfr_bank_with_relocatable_serial_port_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SFR bank with relocatable serial port
// Sixteen byte registers at ports 0xfff0-0xffff, clock selection by register
// pattern, and a four-port serial window placed by the OPHA and SULA bytes.
// ----------------------------------------------------------------------------
// Each access word is decoded and applied in the cycle it is accepted, and its
// result word is registered, so one word is taken every clock cycle while the
// result register drains and the result appears in the cycle after; a single
// output register holds it, and a new word is accepted whenever that register is empty or being drained.
module sfr_bank_with_relocatable_serial_port_top (
    input  logic     clk,
    input  logic     rst_n,
    sfrb_in_if.sink  in_word,
    sfrb_out_if.source out_word
);

    logic [7:0] regs_reg [sfrb_pkg::NUM_REGS];
    logic [7:0] regs_next [sfrb_pkg::NUM_REGS];
    logic [7:0] ser_data_reg, ser_data_next;
    logic [7:0] ser_mode_reg, ser_mode_next;
    logic [7:0] ser_cmd_reg, ser_cmd_next;
    logic [7:0] ser_status_reg, ser_status_next;
    logic       slow_reg, slow_next;
    logic       out_valid_reg;
    sfrb_pkg::out_word_t out_data_reg, out_data_next;

    logic                        accept;
    logic                        is_write;
    logic                        bank_hit;
    logic                        win_hit;
    logic [sfrb_pkg::IDX_W-1:0]  idx;
    logic [1:0]                  off;
    logic [7:0]                  rd;

    assign in_word.ready  = !out_valid_reg || out_word.ready;
    assign accept         = in_word.valid && in_word.ready;
    assign out_word.valid = out_valid_reg;
    assign out_word.data  = out_data_reg;

    assign is_write = (in_word.data.cmd == sfrb_pkg::CMD_WRITE);
    assign idx      = in_word.data.port_address[sfrb_pkg::IDX_W-1:0];
    assign off      = in_word.data.port_address[1:0];
    assign bank_hit = (in_word.data.port_address[15:4] == sfrb_pkg::BANK_PAGE);
    assign win_hit  = !bank_hit
                   && regs_reg[sfrb_pkg::IDX_OPSEL][sfrb_pkg::OPSEL_SER_BIT]
                   && (in_word.data.port_address[15:2] ==
                       {regs_reg[sfrb_pkg::IDX_OPHA], regs_reg[sfrb_pkg::IDX_SULA][7:2]});

    always_comb
    begin
        regs_next       = regs_reg;
        ser_data_next   = ser_data_reg;
        ser_mode_next   = ser_mode_reg;
        ser_cmd_next    = ser_cmd_reg;
        ser_status_next = ser_status_reg;
        slow_next       = slow_reg;
        rd              = sfrb_pkg::UNCLAIMED_DATA;
        if (bank_hit)
        begin
            if (is_write)
            begin
                regs_next[idx] = in_word.data.write_data;
                if (idx == sfrb_pkg::IDX_RFC || idx == sfrb_pkg::IDX_WCY1
                    || idx == sfrb_pkg::IDX_WCY2)
                begin
                    if (regs_next[sfrb_pkg::IDX_RFC] == sfrb_pkg::SLOW_RFC
                        && regs_next[sfrb_pkg::IDX_WCY1] == sfrb_pkg::SLOW_WCY1
                        && regs_next[sfrb_pkg::IDX_WCY2] == sfrb_pkg::CLK_WCY2)
                    begin
                        slow_next = 1'b1;
                    end
                    else if (regs_next[sfrb_pkg::IDX_RFC] == sfrb_pkg::FAST_RFC
                        && regs_next[sfrb_pkg::IDX_WCY1] == sfrb_pkg::FAST_WCY1
                        && regs_next[sfrb_pkg::IDX_WCY2] == sfrb_pkg::CLK_WCY2)
                    begin
                        slow_next = 1'b0;
                    end
                end
            end
            else
            begin
                rd = regs_reg[idx];
            end
        end
        else if (win_hit)
        begin
            unique case (off)
                sfrb_pkg::SER_DATA:
                begin
                    if (is_write)
                    begin
                        ser_data_next   = in_word.data.write_data;
                        ser_status_next = ser_status_reg | sfrb_pkg::STATUS_TX_SET;
                    end
                    else
                    begin
                        ser_status_next = ser_status_reg & sfrb_pkg::STATUS_RX_MASK;
                        rd              = ser_data_reg;
                    end
                end
                sfrb_pkg::SER_STATUS:
                begin
                    rd = ser_status_reg;
                end
                sfrb_pkg::SER_MODE:
                begin
                    if (is_write)
                    begin
                        ser_mode_next = in_word.data.write_data;
                    end
                    rd = ser_mode_reg;
                end
                sfrb_pkg::SER_COMMAND:
                begin
                    if (is_write)
                    begin
                        ser_cmd_next = in_word.data.write_data;
                        if (in_word.data.write_data[sfrb_pkg::CMD_RESET_BIT])
                        begin
                            ser_data_next   = 8'h00;
                            ser_mode_next   = 8'h00;
                            ser_status_next = sfrb_pkg::STATUS_RESET;
                        end
                    end
                    rd = ser_cmd_reg;
                end
                default:
                begin
                    rd = sfrb_pkg::UNCLAIMED_DATA;
                end
            endcase
        end
        out_data_next.read_data  = is_write ? 8'h00 : rd;
        out_data_next.claimed    = bank_hit || win_hit;
        out_data_next.clock_slow = slow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sfrb_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= 8'h00;
            end
            ser_data_reg   <= 8'h00;
            ser_mode_reg   <= 8'h00;
            ser_cmd_reg    <= 8'h00;
            ser_status_reg <= sfrb_pkg::STATUS_RESET;
            slow_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                regs_reg       <= regs_next;
                ser_data_reg   <= ser_data_next;
                ser_mode_reg   <= ser_mode_next;
                ser_cmd_reg    <= ser_cmd_next;
                ser_status_reg <= ser_status_next;
                slow_reg       <= slow_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_word.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_result_follows_access: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted access produced no result word");

    a_status_bits_stay_set: assert property (@(posedge clk) disable iff (!rst_n)
        ser_status_reg[0] && ser_status_reg[2])
        else $error("serial status bits 0 and 2 dropped");

    a_clock_changes_on_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
        (slow_reg != $past(slow_reg)) |-> $past(accept && is_write && bank_hit))
        else $error("clock selection changed without a bank write");

    a_result_tracks_clock: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) |-> (out_data_reg.clock_slow == slow_reg))
        else $error("result clock selection differs from state");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SFR bank testbench
// Drives bus access words into the register bank and checks every result
// word against an in-bench model of the bank, the clock pattern detector and
// the relocatable serial window, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        sfrb_pkg::in_word_t word;
        int unsigned        gap;
        bit                 drain;
    } access_item_t;

    typedef struct {
        sfrb_pkg::out_word_t word;
        time                 stamp;
    } result_entry_t;

    logic clk = 1'b0;
    logic rst_n;

    sfrb_in_if  in_if ();
    sfrb_out_if out_if ();

    sfr_bank_with_relocatable_serial_port_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_if),
        .out_word (out_if)
    );

    always #5 clk = ~clk;

    // Model state of the bank and the serial window.
    logic [7:0] sfr_q [sfrb_pkg::NUM_REGS];
    logic [7:0] uart_data;
    logic [7:0] uart_mode;
    logic [7:0] uart_cmd;
    logic [7:0] uart_status;
    logic       slow_clk;

    // Shadow of the bank as the stimulus leaves it, used to aim at the window.
    logic [7:0] gen_regs [sfrb_pkg::NUM_REGS];

    access_item_t  access_queue [$];
    result_entry_t pending_results [$];

    int unsigned n_queued;
    int unsigned n_accepted;
    int unsigned n_errors;
    int unsigned tx_mode;
    bit          drain_next;

    access_item_t  cur_item;
    bit            have_item;
    int unsigned   gap_left;
    bit            tx_busy;

    result_entry_t exp_entry;
    int unsigned   rx_stall;
    int unsigned   rx_mode;
    int unsigned   rx_seen;

    function automatic int unsigned draw_wait(input int unsigned mode);
        case (mode)
            0: return 0;
            1: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 18) : 0;
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    function automatic sfrb_pkg::out_word_t predict_access(input sfrb_pkg::in_word_t acc);
        sfrb_pkg::out_word_t res;
        logic [3:0]          idx;
        logic [1:0]          off;
        logic                win;
        idx = acc.port_address[3:0];
        off = acc.port_address[1:0];
        win = sfr_q[sfrb_pkg::IDX_OPSEL][sfrb_pkg::OPSEL_SER_BIT] &&
              (acc.port_address[15:2] ==
               {sfr_q[sfrb_pkg::IDX_OPHA], sfr_q[sfrb_pkg::IDX_SULA][7:2]});
        res.read_data = sfrb_pkg::UNCLAIMED_DATA;
        res.claimed   = 1'b0;
        if (acc.port_address[15:4] == sfrb_pkg::BANK_PAGE) begin
            res.claimed = 1'b1;
            if (acc.cmd == sfrb_pkg::CMD_WRITE) begin
                sfr_q[idx] = acc.write_data;
                if (idx == sfrb_pkg::IDX_RFC || idx == sfrb_pkg::IDX_WCY1 ||
                    idx == sfrb_pkg::IDX_WCY2) begin
                    if (sfr_q[sfrb_pkg::IDX_RFC] == sfrb_pkg::SLOW_RFC &&
                        sfr_q[sfrb_pkg::IDX_WCY1] == sfrb_pkg::SLOW_WCY1 &&
                        sfr_q[sfrb_pkg::IDX_WCY2] == sfrb_pkg::CLK_WCY2)
                        slow_clk = 1'b1;
                    else if (sfr_q[sfrb_pkg::IDX_RFC] == sfrb_pkg::FAST_RFC &&
                             sfr_q[sfrb_pkg::IDX_WCY1] == sfrb_pkg::FAST_WCY1 &&
                             sfr_q[sfrb_pkg::IDX_WCY2] == sfrb_pkg::CLK_WCY2)
                        slow_clk = 1'b0;
                end
            end
            else
                res.read_data = sfr_q[idx];
        end
        else if (win) begin
            res.claimed = 1'b1;
            if (acc.cmd == sfrb_pkg::CMD_WRITE) begin
                case (off)
                    sfrb_pkg::SER_DATA:
                    begin
                        uart_data   = acc.write_data;
                        uart_status = uart_status | sfrb_pkg::STATUS_TX_SET;
                    end
                    sfrb_pkg::SER_MODE: uart_mode = acc.write_data;
                    sfrb_pkg::SER_COMMAND:
                    begin
                        uart_cmd = acc.write_data;
                        if (acc.write_data[sfrb_pkg::CMD_RESET_BIT]) begin
                            uart_data   = 8'h00;
                            uart_mode   = 8'h00;
                            uart_status = sfrb_pkg::STATUS_RESET;
                        end
                    end
                    default: ;
                endcase
            end
            else begin
                case (off)
                    sfrb_pkg::SER_DATA:
                    begin
                        uart_status   = uart_status & sfrb_pkg::STATUS_RX_MASK;
                        res.read_data = uart_data;
                    end
                    sfrb_pkg::SER_STATUS: res.read_data = uart_status;
                    sfrb_pkg::SER_MODE:   res.read_data = uart_mode;
                    default:              res.read_data = uart_cmd;
                endcase
            end
        end
        if (acc.cmd == sfrb_pkg::CMD_WRITE)
            res.read_data = 8'h00;
        res.clock_slow = slow_clk;
        return res;
    endfunction

    function automatic logic [15:0] window_port(input logic [1:0] off);
        return {gen_regs[sfrb_pkg::IDX_OPHA], gen_regs[sfrb_pkg::IDX_SULA][7:2], off};
    endfunction

    task automatic queue_access(input logic cmd, input logic [15:0] port,
                                input logic [7:0] wdata);
        access_item_t item;
        item.word.cmd          = cmd;
        item.word.port_address = port;
        item.word.write_data   = wdata;
        item.gap   = draw_wait(tx_mode);
        item.drain = drain_next;
        drain_next = 1'b0;
        if (cmd == sfrb_pkg::CMD_WRITE && port[15:4] == sfrb_pkg::BANK_PAGE)
            gen_regs[port[3:0]] = wdata;
        access_queue.push_back(item);
        n_queued++;
    endtask

    task automatic report_mismatch(input string what);
        if (n_errors < 100)
            $display("%0t ns: %s", $time, what);
        n_errors++;
    endtask

    // Driver: presents queued access words and predicts each accepted one.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
            have_item = 1'b0;
            gap_left  = 0;
        end
        else begin
            tx_busy = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                pending_results.push_back('{predict_access(in_if.data), $time});
                n_accepted++;
                tx_busy = 1'b0;
            end
            if (!tx_busy) begin
                if (!have_item && access_queue.size() > 0) begin
                    cur_item  = access_queue.pop_front();
                    have_item = 1'b1;
                    gap_left  = cur_item.gap;
                end
                if (have_item && gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end
                else if (have_item && cur_item.drain && pending_results.size() > 0)
                    in_if.valid <= 1'b0;
                else if (have_item) begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= cur_item.word;
                    have_item = 1'b0;
                end
                else
                    in_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: takes result words with random stalls and checks them in order.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            rx_stall = 0;
            rx_mode  = 0;
            rx_seen  = 0;
        end
        else begin
            if (out_if.valid && out_if.ready) begin
                if (pending_results.size() == 0 || pending_results[0].stamp >= $time)
                    report_mismatch($sformatf("unexpected result word %h", out_if.data));
                else begin
                    exp_entry = pending_results.pop_front();
                    if (out_if.data !== exp_entry.word)
                        report_mismatch($sformatf(
                            "result read_data %h claimed %b slow %b, wanted %h %b %b",
                            out_if.data.read_data, out_if.data.claimed,
                            out_if.data.clock_slow, exp_entry.word.read_data,
                            exp_entry.word.claimed, exp_entry.word.clock_slow));
                end
                rx_seen++;
                if (rx_seen % 97 == 0)
                    rx_mode = $urandom_range(0, 2);
                rx_stall = draw_wait(rx_mode);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= 1'b1;
        end
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int unsigned pick;
        int unsigned kind;
        int unsigned rot;
        int unsigned next_drain;
        logic [1:0]  off;
        logic [7:0]  wd;
        logic [7:0]  rv;
        logic [7:0]  w1v;
        logic [7:0]  w2v;

        rst_n = 1'b0;
        for (int i = 0; i < sfrb_pkg::NUM_REGS; i++) begin
            sfr_q[i]    = 8'h00;
            gen_regs[i] = 8'h00;
        end
        uart_data   = 8'h00;
        uart_mode   = 8'h00;
        uart_cmd    = 8'h00;
        uart_status = sfrb_pkg::STATUS_RESET;
        slow_clk    = 1'b0;
        n_queued    = 0;
        n_accepted  = 0;
        n_errors    = 0;
        drain_next  = 1'b0;
        tx_mode     = 2;

        // Bank extremes, unclaimed ports, both clock patterns and a miss.
        queue_access(sfrb_pkg::CMD_READ,  {sfrb_pkg::BANK_PAGE, 4'h0}, 8'h00);
        queue_access(sfrb_pkg::CMD_READ,  {sfrb_pkg::BANK_PAGE, 4'hf}, 8'h00);
        queue_access(sfrb_pkg::CMD_WRITE, {sfrb_pkg::BANK_PAGE, 4'h0}, 8'h00);
        queue_access(sfrb_pkg::CMD_WRITE, {sfrb_pkg::BANK_PAGE, 4'hf}, 8'hff);
        queue_access(sfrb_pkg::CMD_READ,  16'h0000, 8'h00);
        queue_access(sfrb_pkg::CMD_WRITE, 16'h1234, 8'h5a);
        queue_access(sfrb_pkg::CMD_WRITE, {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_RFC},
                     sfrb_pkg::SLOW_RFC);
        queue_access(sfrb_pkg::CMD_WRITE, {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_WCY1},
                     sfrb_pkg::SLOW_WCY1);
        queue_access(sfrb_pkg::CMD_WRITE, {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_WCY2},
                     sfrb_pkg::CLK_WCY2);
        queue_access(sfrb_pkg::CMD_WRITE, {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_RFC}, 8'h11);
        queue_access(sfrb_pkg::CMD_WRITE, {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_RFC},
                     sfrb_pkg::FAST_RFC);
        queue_access(sfrb_pkg::CMD_WRITE, {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_WCY1},
                     sfrb_pkg::FAST_WCY1);
        // Serial window at 0x1234 and every one of its ports.
        queue_access(sfrb_pkg::CMD_WRITE, {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_OPSEL}, 8'h08);
        queue_access(sfrb_pkg::CMD_WRITE, {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_OPHA},  8'h12);
        queue_access(sfrb_pkg::CMD_WRITE, {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_SULA},  8'h37);
        queue_access(sfrb_pkg::CMD_WRITE, window_port(sfrb_pkg::SER_DATA),    8'ha5);
        queue_access(sfrb_pkg::CMD_READ,  window_port(sfrb_pkg::SER_STATUS),  8'h00);
        queue_access(sfrb_pkg::CMD_READ,  window_port(sfrb_pkg::SER_DATA),    8'h00);
        queue_access(sfrb_pkg::CMD_WRITE, window_port(sfrb_pkg::SER_MODE),    8'h5a);
        queue_access(sfrb_pkg::CMD_WRITE, window_port(sfrb_pkg::SER_STATUS),  8'hff);
        queue_access(sfrb_pkg::CMD_WRITE, window_port(sfrb_pkg::SER_COMMAND), 8'hc0);
        queue_access(sfrb_pkg::CMD_READ,  window_port(sfrb_pkg::SER_COMMAND), 8'h00);
        queue_access(sfrb_pkg::CMD_READ,  window_port(sfrb_pkg::SER_MODE),    8'h00);
        // Window laid over the bank: the bank answers.
        queue_access(sfrb_pkg::CMD_WRITE, {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_OPHA}, 8'hff);
        queue_access(sfrb_pkg::CMD_WRITE, {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_SULA}, 8'hf3);
        queue_access(sfrb_pkg::CMD_READ,  {sfrb_pkg::BANK_PAGE, 4'h0},              8'h00);

        drain_next = 1'b1;
        next_drain = n_queued + 600;
        while (n_queued < 1800) begin
            if ($urandom_range(0, 59) == 0)
                tx_mode = $urandom_range(0, 2);
            if (n_queued >= next_drain) begin
                drain_next = 1'b1;
                next_drain += 600;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                off = 2'($urandom_range(0, 3));
                wd  = 8'($urandom);
                queue_access(1'($urandom_range(0, 1)), window_port(off), wd);
            end
            else if (pick < 60) begin
                wd = 8'($urandom);
                queue_access(1'($urandom_range(0, 1)),
                             {sfrb_pkg::BANK_PAGE, 4'($urandom_range(0, 15))}, wd);
            end
            else if (pick < 70) begin
                kind = $urandom_range(0, 1);
                rv   = (kind == 0) ? sfrb_pkg::SLOW_RFC : sfrb_pkg::FAST_RFC;
                w1v  = (kind == 0) ? sfrb_pkg::SLOW_WCY1 : sfrb_pkg::FAST_WCY1;
                w2v  = sfrb_pkg::CLK_WCY2;
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 2))
                        0: rv  = rv  ^ (8'h01 << $urandom_range(0, 7));
                        1: w1v = w1v ^ (8'h01 << $urandom_range(0, 7));
                        default: w2v = w2v ^ (8'h01 << $urandom_range(0, 7));
                    endcase
                end
                rot = $urandom_range(0, 2);
                for (int k = 0; k < 3; k++) begin
                    case ((k + rot) % 3)
                        0: queue_access(sfrb_pkg::CMD_WRITE,
                                        {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_RFC}, rv);
                        1: queue_access(sfrb_pkg::CMD_WRITE,
                                        {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_WCY1}, w1v);
                        default: queue_access(sfrb_pkg::CMD_WRITE,
                                        {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_WCY2}, w2v);
                    endcase
                end
            end
            else if (pick < 80) begin
                wd = 8'($urandom);
                if ($urandom_range(0, 4) != 0)
                    wd[sfrb_pkg::OPSEL_SER_BIT] = 1'b1;
                queue_access(sfrb_pkg::CMD_WRITE,
                             {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_OPSEL}, wd);
                wd = ($urandom_range(0, 7) == 0) ? 8'hff : 8'($urandom);
                queue_access(sfrb_pkg::CMD_WRITE,
                             {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_OPHA}, wd);
                wd = 8'($urandom);
                queue_access(sfrb_pkg::CMD_WRITE,
                             {sfrb_pkg::BANK_PAGE, sfrb_pkg::IDX_SULA}, wd);
            end
            else begin
                wd = 8'($urandom);
                queue_access(1'($urandom_range(0, 1)), 16'($urandom), wd);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted != n_queued || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/sfrb_pkg.sv
rtl/sfrb_in_if.sv
rtl/sfrb_out_if.sv
rtl/sfr_bank_with_relocatable_serial_port_top.sv
sim/tb.sv
